// ===== rtl/core/tsde_pkg.sv =====
// Package for the trigonometric series derivative evaluator.
// Holds payload and control types, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsde_pkg;

    // Sizes
    localparam int MAX_TERMS_DEF = 64;
    localparam int PH_W          = 32;   // phase, Q3.29 unsigned
    localparam int CW            = 34;   // CORDIC working width
    localparam int CORDIC_STEPS  = 30;
    localparam int J_W           = 5;    // CORDIC iteration index
    localparam int STEP_W        = 6;    // controller step counter
    localparam int MAG_W         = 42;   // rounded term magnitude
    localparam int P_W           = 63;   // power i^k, saturating
    localparam int TERM_STEPS    = MAG_W;
    localparam int CFG_IDX_W     = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b1;

    // Fixed-point constants
    localparam logic signed [CW-1:0] TWO_PI_Q29  = 34'sd3373259426;
    localparam logic signed [CW-1:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [CW-1:0] HALF_PI_Q29 = 34'sd843314856;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [63:0]   MINUS_ONE_Q24 = -64'sd16777216;
    localparam logic [P_W-1:0]       P_MAX = {P_W{1'b1}};

    typedef struct packed {
        logic signed [31:0] sine_coef;
        logic signed [31:0] cosine_coef;
        logic               last_term;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] series_value;
        logic               order_invalid;
        logic               overflowed;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL_A,
        S_MUL_B,
        S_ROUND,
        S_SIGN,
        S_TERM,
        S_ACCUM,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic           load;
        logic           cordic_step;
        logic           mul_a;
        logic           mul_b;
        logic           round;
        logic           sign;
        logic           term_step;
        logic           accum;
        logic           emit;
        logic [J_W-1:0] step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_last;
        logic in_neg;
        logic cur_last;
        logic out_busy;
    } status_t;

    // Arctangent of 2^-j, Q2.30, truncated
    function automatic logic [31:0] atan_q30(input logic [J_W-1:0] j);
        logic [31:0] r;
        unique case (j)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000007;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsde_ctrl.sv =====
// Controller for the series evaluator: sequences CORDIC, products, rounding,
// bit-serial term scaling and accumulation. Depends on tsde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsde_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tsde_pkg::status_t status,
    output tsde_pkg::cmd_t         cmd
);

    tsde_pkg::state_t                    state_reg, state_next;
    logic [tsde_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                                cordic_done, term_done;

    assign cordic_done = (step_reg == tsde_pkg::STEP_W'(tsde_pkg::CORDIC_STEPS - 1));
    assign term_done   = (step_reg == tsde_pkg::STEP_W'(tsde_pkg::TERM_STEPS - 1));

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsde_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsde_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!status.in_neg)
                        state_next = tsde_pkg::S_CORDIC;
                    else if (status.in_last)
                        state_next = tsde_pkg::S_EMIT;
                end
            end
            tsde_pkg::S_CORDIC: if (cordic_done) state_next = tsde_pkg::S_MUL_A;
            tsde_pkg::S_MUL_A:  state_next = tsde_pkg::S_MUL_B;
            tsde_pkg::S_MUL_B:  state_next = tsde_pkg::S_ROUND;
            tsde_pkg::S_ROUND:  state_next = tsde_pkg::S_SIGN;
            tsde_pkg::S_SIGN:   state_next = tsde_pkg::S_TERM;
            tsde_pkg::S_TERM:   if (term_done) state_next = tsde_pkg::S_ACCUM;
            tsde_pkg::S_ACCUM:
                state_next = status.cur_last ? tsde_pkg::S_EMIT : tsde_pkg::S_IDLE;
            tsde_pkg::S_EMIT:   if (!status.out_busy) state_next = tsde_pkg::S_IDLE;
            default:            state_next = tsde_pkg::S_IDLE;
        endcase
    end

    // Step counter runs through CORDIC and term scaling
    always_comb
    begin
        step_next = '0;
        if ((state_reg == tsde_pkg::S_CORDIC && !cordic_done) ||
            (state_reg == tsde_pkg::S_TERM && !term_done))
            step_next = step_reg + 1'b1;
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.step = step_reg[tsde_pkg::J_W-1:0];
        in_stall = 1'b1;
        unique case (state_reg)
            tsde_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            tsde_pkg::S_CORDIC: cmd.cordic_step = 1'b1;
            tsde_pkg::S_MUL_A:  cmd.mul_a       = 1'b1;
            tsde_pkg::S_MUL_B:  cmd.mul_b       = 1'b1;
            tsde_pkg::S_ROUND:  cmd.round       = 1'b1;
            tsde_pkg::S_SIGN:   cmd.sign        = 1'b1;
            tsde_pkg::S_TERM:   cmd.term_step   = 1'b1;
            tsde_pkg::S_ACCUM:  cmd.accum       = 1'b1;
            tsde_pkg::S_EMIT:   cmd.emit        = !status.out_busy;
            default:            cmd.load        = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsde_dp.sv =====
// Datapath of the series evaluator: configuration, phase and index tracking,
// CORDIC, shared multiplier, saturating power, term scaling, accumulator, output register.
// Depends on tsde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsde_dp #(
    parameter int MAX_TERMS = tsde_pkg::MAX_TERMS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tsde_pkg::cmd_t                    cmd,
    output tsde_pkg::status_t                      status,
    input  wire tsde_pkg::in_item_t                in_data,
    input  wire logic                              cfg_valid,
    input  wire logic [tsde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output tsde_pkg::out_item_t                    out_data
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW    = tsde_pkg::CW;
    localparam int PW    = tsde_pkg::P_W;
    localparam int MW    = tsde_pkg::MAG_W;

    // Configuration and series state
    logic signed [31:0]        angle_reg;
    logic signed [4:0]         order_reg;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [tsde_pkg::PH_W-1:0] phase_reg, phase_next;
    logic signed [63:0]        sum_reg, sum_next;
    logic                      sat_reg, sat_next;
    logic                      out_valid_reg, out_valid_next;

    // Per-item working registers
    logic signed [31:0]        a_reg, b_reg;
    logic signed [4:0]         k_reg;
    logic                      last_reg;
    logic [IDX_W-1:0]          i_reg;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    logic                      fold_reg;
    logic [PW-1:0]             p_reg;
    logic [3:0]                pcnt_reg;
    logic signed [63:0]        prod_a_reg, prod_b_reg;
    logic signed [MW-1:0]      v_reg;
    logic [MW-1:0]             mag_reg;
    logic                      vneg_reg;
    logic [PW-1:0]             tacc_reg;
    logic                      tovf_reg;
    tsde_pkg::out_item_t       out_reg;

    assign status.in_last  = in_data.last_term;
    assign status.in_neg   = order_reg[4];
    assign status.cur_last = last_reg;
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            order_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tsde_pkg::CFG_ANGLE)
                angle_reg <= cfg_data;
            else if (cfg_index == tsde_pkg::CFG_ORDER)
                order_reg <= cfg_data[4:0];
        end
    end

    // Phase advance and term index on each accepted item
    logic signed [CW-1:0] xr, np;
    always_comb
    begin
        xr = CW'(angle_reg);
        if (angle_reg < 0)
            xr = xr + tsde_pkg::TWO_PI_Q29;
        np = $signed({2'b00, phase_reg}) + xr;
        if (np >= tsde_pkg::TWO_PI_Q29)
            np = np - tsde_pkg::TWO_PI_Q29;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (cmd.load)
        begin
            if (in_data.last_term || idx_reg == IDX_W'(MAX_TERMS - 1))
            begin
                idx_next   = '0;
                phase_next = '0;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                phase_next = np[tsde_pkg::PH_W-1:0];
            end
        end
    end

    // Phase folding into [-pi/2, pi/2] for the CORDIC start
    logic signed [CW-1:0] t1, t2;
    logic                 fold;
    always_comb
    begin
        t1 = $signed({2'b00, phase_reg});
        if (t1 > tsde_pkg::PI_Q29)
            t1 = t1 - tsde_pkg::TWO_PI_Q29;
        fold = 1'b0;
        t2   = t1;
        if (t1 > tsde_pkg::HALF_PI_Q29)
        begin
            t2   = t1 - tsde_pkg::PI_Q29;
            fold = 1'b1;
        end
        else if (t1 < -tsde_pkg::HALF_PI_Q29)
        begin
            t2   = t1 + tsde_pkg::PI_Q29;
            fold = 1'b1;
        end
    end

    // One CORDIC rotation
    logic signed [CW-1:0] sx, sy, at;
    always_comb
    begin
        sx = x_reg >>> cmd.step;
        sy = y_reg >>> cmd.step;
        at = $signed({2'b00, tsde_pkg::atan_q30(cmd.step)});
    end

    // Saturating power step, overlapped with CORDIC
    logic [PW+IDX_W-1:0] pprod;
    assign pprod = p_reg * i_reg;

    // Shared 32x32 multiplier
    logic signed [31:0] cs, sn, m_op1, m_op2;
    logic signed [63:0] m_prod;
    always_comb
    begin
        cs = fold_reg ? -x_reg[31:0] : x_reg[31:0];
        sn = fold_reg ? -y_reg[31:0] : y_reg[31:0];
        if (cmd.mul_b)
        begin
            m_op1 = b_reg;
            m_op2 = k_reg[0] ? sn : cs;
        end
        else
        begin
            m_op1 = a_reg;
            m_op2 = k_reg[0] ? cs : sn;
        end
        m_prod = 64'(m_op1) * 64'(m_op2);
    end

    // Sign pattern by k mod 4, then round to Q18.24
    logic signed [63:0] raw, rnd;
    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    raw = prod_a_reg + prod_b_reg;
            2'd1:    raw = prod_a_reg - prod_b_reg;
            2'd2:    raw = -prod_a_reg - prod_b_reg;
            default: raw = prod_b_reg - prod_a_reg;
        endcase
        rnd = raw + 64'sd2097152;
    end

    // Bit-serial scaling of the magnitude by i^k
    logic [PW+1:0] tsum;
    assign tsum = {1'b0, tacc_reg, 1'b0} + (mag_reg[MW-1] ? {2'b00, p_reg} : '0);

    // Saturating accumulation
    logic signed [63:0] term_val, acc_sum;
    logic               acc_ovf;
    always_comb
    begin
        if (tovf_reg)
            term_val = vneg_reg ? {1'b1, 63'd0} : {1'b0, tsde_pkg::P_MAX};
        else if (vneg_reg)
            term_val = -$signed({1'b0, tacc_reg});
        else
            term_val = $signed({1'b0, tacc_reg});
        acc_sum = sum_reg + term_val;
        acc_ovf = (sum_reg[63] == term_val[63]) && (acc_sum[63] != sum_reg[63]);
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (cmd.accum)
        begin
            sum_next = acc_ovf ? (sum_reg[63] ? {1'b1, 63'd0} : {1'b0, tsde_pkg::P_MAX})
                               : acc_sum;
            sat_next = sat_reg | tovf_reg | acc_ovf;
        end
        else if (cmd.emit)
        begin
            sum_next = '0;
            sat_next = 1'b0;
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
            out_valid_next = 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            phase_reg     <= '0;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= in_data.sine_coef;
            b_reg    <= in_data.cosine_coef;
            last_reg <= in_data.last_term;
            k_reg    <= order_reg;
            i_reg    <= idx_reg;
            x_reg    <= tsde_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= t2 <<< 1;
            fold_reg <= fold;
            p_reg    <= PW'(1);
            pcnt_reg <= order_reg[3:0];
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + at;
            end
            if (pcnt_reg != 4'd0)
            begin
                p_reg    <= (pprod > (PW+IDX_W)'(tsde_pkg::P_MAX)) ? tsde_pkg::P_MAX
                                                                  : pprod[PW-1:0];
                pcnt_reg <= pcnt_reg - 1'b1;
            end
        end
        if (cmd.mul_a)
            prod_a_reg <= m_prod;
        if (cmd.mul_b)
            prod_b_reg <= m_prod;
        if (cmd.round)
            v_reg <= rnd[63:64-MW];
        if (cmd.sign)
        begin
            vneg_reg <= v_reg[MW-1];
            mag_reg  <= v_reg[MW-1] ? MW'(-v_reg) : MW'(v_reg);
            tacc_reg <= '0;
            tovf_reg <= 1'b0;
        end
        if (cmd.term_step)
        begin
            mag_reg <= mag_reg << 1;
            if (tsum > {2'b00, tsde_pkg::P_MAX})
            begin
                tacc_reg <= tsde_pkg::P_MAX;
                tovf_reg <= 1'b1;
            end
            else
                tacc_reg <= tsum[PW-1:0];
        end
        if (cmd.emit)
        begin
            if (k_reg[4])
            begin
                out_reg.series_value  <= tsde_pkg::MINUS_ONE_Q24;
                out_reg.order_invalid <= 1'b1;
                out_reg.overflowed    <= 1'b0;
            end
            else
            begin
                out_reg.series_value  <= sum_reg;
                out_reg.order_invalid <= 1'b0;
                out_reg.overflowed    <= sat_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/trig_series_derivative_eval.sv =====
// Trigonometric series derivative evaluator, top level; depends on tsde_pkg, tsde_ctrl, tsde_dp.
// Each term runs 30 CORDIC rotations, two passes of one 32x32 multiplier, rounding, a sign split,
// 42 bit-serial scaling steps and accumulate; i^k is overlapped with CORDIC. Input stalls until
// a term is done; a last term then passes an emit state that loads the output register, waiting
// while the output stalls. Negative order: terms skip the arithmetic; a last term goes to emit.
// Reset clears registers, term index, phase, accumulator and flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module trig_series_derivative_eval #(
    parameter int MAX_TERMS = tsde_pkg::MAX_TERMS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire tsde_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output tsde_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tsde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    tsde_pkg::cmd_t    cmd;
    tsde_pkg::status_t status;

    // Register writes are taken at any time
    assign cfg_ready = 1'b1;

    tsde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tsde_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
